@@ rtl/snfce_pkg.sv @@
`timescale 1ns / 1ps

package snfce_pkg;

    typedef enum logic [1:0] {
        FN_SELECT  = 2'd0,
        FN_RELEASE = 2'd1,
        FN_WRITE   = 2'd2,
        FN_READ    = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_DATA
    } t_state;

    typedef enum logic [1:0] {
        AS_CLEAR,
        AS_IDLE,
        AS_PROG,
        AS_ERASE
    } t_arr_state;

    localparam logic [7:0] OP_NONE    = 8'h00;
    localparam logic [7:0] OP_PROGRAM = 8'h02;
    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_WRDI    = 8'h04;
    localparam logic [7:0] OP_STATUS  = 8'h05;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_ERASE   = 8'h20;
    localparam logic [7:0] OP_ID      = 8'h9F;
    localparam logic [7:0] OP_ADDR4   = 8'hB7;
    localparam logic [7:0] OP_ADDR3   = 8'hE9;

    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam int          PAGE_BITS   = 8;
    localparam int          SECTOR_BITS = 12;
    localparam logic [8:0]  PAGE_FULL   = 9'h100;
    localparam logic [2:0]  IDX_MAX     = 3'd7;
    localparam logic [2:0]  ADDR_LEN3   = 3'd3;
    localparam logic [2:0]  ADDR_LEN4   = 3'd4;
    localparam logic [31:0] ID_LEN      = 32'd20;

    typedef struct packed {
        logic       rd_en;
        logic       pb_wr_en;
        logic [7:0] pb_idx;
        logic [7:0] pb_data;
        logic       prog_go;
        logic       erase_go;
        logic [7:0] buf_start;
        logic [8:0] buf_count;
    } t_arr_req;

    function automatic logic [7:0] id_byte(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:    v = 8'h20;
            5'd1:    v = 8'hBA;
            5'd2:    v = 8'h19;
            5'd3:    v = 8'h10;
            5'd4:    v = 8'h00;
            5'd5:    v = 8'h00;
            5'd6:    v = 8'h23;
            5'd7:    v = 8'h21;
            5'd8:    v = 8'h61;
            5'd9:    v = 8'h34;
            5'd10:   v = 8'h07;
            5'd11:   v = 8'h00;
            5'd12:   v = 8'h30;
            5'd13:   v = 8'h00;
            5'd14:   v = 8'h17;
            5'd15:   v = 8'h17;
            5'd16:   v = 8'h06;
            5'd17:   v = 8'h12;
            5'd18:   v = 8'h4B;
            5'd19:   v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/snfce_array.sv @@
`timescale 1ns / 1ps

module snfce_array #(
    parameter int ADDR_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  snfce_pkg::t_arr_req   i_req,
    input  logic [ADDR_BITS-1:0]  i_addr,
    output logic                  o_busy,
    output logic [7:0]            o_rd_data
);
    import snfce_pkg::*;

    localparam int DEPTH    = 1 << ADDR_BITS;
    localparam int PB_DEPTH = 1 << PAGE_BITS;

    logic [7:0] r_flash [DEPTH];
    logic [7:0] r_page [PB_DEPTH];

    t_arr_state r_state, n_state;
    logic [ADDR_BITS-1:0]   r_clr, n_clr;
    logic [SECTOR_BITS-1:0] r_step, n_step;
    logic [ADDR_BITS-1:0]   r_base, n_base;
    logic [7:0]             r_start, n_start;
    logic [8:0]             r_count, n_count;
    logic                   r_pb_v, n_pb_v;
    logic [ADDR_BITS-1:0]   r_wr_idx, n_wr_idx;
    logic [7:0]             r_pb_q;
    logic [7:0]             r_rd_q;

    logic                   prog_more;
    logic                   pb_re;
    logic [7:0]             pb_ridx;
    logic                   fl_we;
    logic [ADDR_BITS-1:0]   fl_widx;
    logic [7:0]             fl_wdata;

    assign prog_more = r_step < {{(SECTOR_BITS-9){1'b0}}, r_count};

    always_comb begin
        n_state = r_state;
        case (r_state)
            AS_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = AS_IDLE;
                end
            end
            AS_IDLE: begin
                if (i_req.prog_go) begin
                    n_state = AS_PROG;
                end else if (i_req.erase_go) begin
                    n_state = AS_ERASE;
                end
            end
            AS_PROG: begin
                if (!prog_more) begin
                    n_state = AS_IDLE;
                end
            end
            AS_ERASE: begin
                if (r_step == '1) begin
                    n_state = AS_IDLE;
                end
            end
            default: n_state = AS_IDLE;
        endcase
    end

    always_comb begin
        n_clr    = r_clr;
        n_step   = r_step;
        n_base   = r_base;
        n_start  = r_start;
        n_count  = r_count;
        n_pb_v   = 1'b0;
        n_wr_idx = r_wr_idx;
        pb_re    = 1'b0;
        pb_ridx  = r_start + r_step[PAGE_BITS-1:0];
        fl_we    = r_pb_v;
        fl_widx  = r_wr_idx;
        fl_wdata = r_pb_q;
        case (r_state)
            AS_CLEAR: begin
                fl_we    = 1'b1;
                fl_widx  = r_clr;
                fl_wdata = ERASED_BYTE;
                n_clr    = r_clr + 1'b1;
            end
            AS_IDLE: begin
                n_step = '0;
                if (i_req.prog_go || i_req.erase_go) begin
                    n_base = i_addr;
                end
                if (i_req.prog_go) begin
                    n_start = i_req.buf_start;
                    n_count = i_req.buf_count;
                end
            end
            AS_PROG: begin
                if (prog_more) begin
                    pb_re    = 1'b1;
                    n_pb_v   = 1'b1;
                    n_wr_idx = {r_base[ADDR_BITS-1:PAGE_BITS],
                                r_base[PAGE_BITS-1:0] + r_step[PAGE_BITS-1:0]};
                    n_step   = r_step + 1'b1;
                end
            end
            AS_ERASE: begin
                fl_we    = 1'b1;
                fl_widx  = {r_base[ADDR_BITS-1:SECTOR_BITS], r_step};
                fl_wdata = ERASED_BYTE;
                n_step   = r_step + 1'b1;
            end
            default: begin
                n_step = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_CLEAR;
            r_clr   <= '0;
            r_step  <= '0;
            r_pb_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_step  <= n_step;
            r_pb_v  <= n_pb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_start  <= n_start;
        r_count  <= n_count;
        r_wr_idx <= n_wr_idx;
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            r_flash[fl_widx] <= fl_wdata;
        end
        if (i_req.rd_en) begin
            r_rd_q <= r_flash[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pb_wr_en) begin
            r_page[i_req.pb_idx] <= i_req.pb_data;
        end
        if (pb_re) begin
            r_pb_q <= r_page[pb_ridx];
        end
    end

    assign o_busy    = (r_state != AS_IDLE);
    assign o_rd_data = r_rd_q;

endmodule

@@ rtl/spi_nor_flash_command_engine.sv @@
`timescale 1ns / 1ps
// Device side of an SPI NOR flash, driven one bus event per input transaction.
// The input channel carries i_func (select, release, write byte, read byte) and
// i_write_byte under i_valid / o_stall; the output channel returns exactly one
// o_read_byte per input transaction under o_valid / i_stall.
// Most transactions produce their result in the cycle after acceptance, and a new
// transaction can be accepted every cycle while the result register drains and
// no array read or walk is under way. A data read of the array passes through
// the synchronous array read register and then the result register. A release
// that ends a page program walks the buffered bytes of the page buffer into the
// array; one that ends a subsector erase writes 4096 bytes. The input is stalled
// during these walks. After reset, the array is filled with 0xFF by a clearing
// pass over all 2^ADDR_BITS bytes, during which o_stall stays high.
// When the receiver stalls, the pending result holds in the output register and
// the input is stalled until that result is taken.
module spi_nor_flash_command_engine #(
    parameter int ADDR_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_write_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_byte
);
    import snfce_pkg::*;

    t_state      r_state, n_state;
    logic [7:0]  r_command, n_command;
    logic [2:0]  r_byte_idx, n_byte_idx;
    logic        r_wen, n_wen;
    logic        r_four, n_four;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_buf_start, n_buf_start;
    logic [8:0]  r_buf_count, n_buf_count;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data, n_out_data;

    t_arr_req    arr_req;
    logic        arr_busy;
    logic [7:0]  arr_rd_data;
    logic        accept;
    logic [2:0]  addr_len;
    logic        addr_phase;
    logic        flash_rd;

    assign o_stall    = (r_state != ST_IDLE) || arr_busy || (r_out_valid && i_stall);
    assign accept     = i_valid && !o_stall;
    assign addr_len   = r_four ? ADDR_LEN4 : ADDR_LEN3;
    assign addr_phase = (r_byte_idx <= addr_len);
    assign flash_rd   = (t_func'(i_func) == FN_READ) && (r_byte_idx != 3'd0) &&
                        (r_command == OP_READ) && !addr_phase;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && flash_rd) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_command   = r_command;
        n_byte_idx  = r_byte_idx;
        n_wen       = r_wen;
        n_four      = r_four;
        n_addr      = r_addr;
        n_buf_start = r_buf_start;
        n_buf_count = r_buf_count;
        n_out_valid = r_out_valid && i_stall;
        n_out_data  = r_out_data;
        arr_req     = '0;

        if (r_state == ST_DATA) begin
            n_out_valid = 1'b1;
            n_out_data  = arr_rd_data;
        end

        if (accept) begin
            n_out_valid = 1'b1;
            n_out_data  = 8'h00;
            case (t_func'(i_func))
                FN_SELECT: begin
                    n_command  = OP_NONE;
                    n_byte_idx = 3'd0;
                    n_addr     = '0;
                end
                FN_RELEASE: begin
                    if (r_command == OP_PROGRAM) begin
                        arr_req.prog_go   = 1'b1;
                        arr_req.buf_start = r_buf_start;
                        arr_req.buf_count = r_buf_count;
                        n_wen             = 1'b0;
                    end else if (r_command == OP_ERASE) begin
                        arr_req.erase_go = 1'b1;
                        n_wen            = 1'b0;
                    end
                end
                FN_WRITE: begin
                    if (r_byte_idx == 3'd0) begin
                        n_command = i_write_byte;
                        case (i_write_byte)
                            OP_PROGRAM: begin
                                if (!r_wen) begin
                                    n_command = OP_NONE;
                                end
                                n_buf_start = 8'h00;
                                n_buf_count = 9'h000;
                            end
                            OP_WRDI:  n_wen  = 1'b0;
                            OP_WREN:  n_wen  = 1'b1;
                            OP_ERASE: begin
                                if (!r_wen) begin
                                    n_command = OP_NONE;
                                end
                            end
                            OP_ADDR4: n_four = 1'b1;
                            OP_ADDR3: n_four = 1'b0;
                            default:  n_command = i_write_byte;
                        endcase
                    end else if (r_command inside {OP_PROGRAM, OP_READ, OP_ERASE}) begin
                        if (addr_phase) begin
                            n_addr = {r_addr[23:0], i_write_byte};
                        end else if (r_command == OP_PROGRAM) begin
                            arr_req.pb_wr_en = 1'b1;
                            arr_req.pb_idx   = r_buf_start + r_buf_count[7:0];
                            arr_req.pb_data  = i_write_byte;
                            if (r_buf_count == PAGE_FULL) begin
                                n_buf_start = r_buf_start + 8'h01;
                            end else begin
                                n_buf_count = r_buf_count + 9'h001;
                            end
                        end
                    end
                    if (r_byte_idx != IDX_MAX) begin
                        n_byte_idx = r_byte_idx + 3'd1;
                    end
                end
                FN_READ: begin
                    if (flash_rd) begin
                        arr_req.rd_en = 1'b1;
                        n_addr        = r_addr + 32'd1;
                        n_out_valid   = 1'b0;
                    end else if (r_byte_idx != 3'd0) begin
                        case (r_command)
                            OP_STATUS: n_out_data = {6'b000000, r_wen, 1'b0};
                            OP_ID: begin
                                if (r_addr < ID_LEN) begin
                                    n_out_data = id_byte(r_addr[4:0]);
                                    n_addr     = r_addr + 32'd1;
                                end
                            end
                            default: n_out_data = 8'h00;
                        endcase
                    end
                end
                default: n_out_data = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_command   <= OP_NONE;
            r_byte_idx  <= 3'd0;
            r_wen       <= 1'b0;
            r_four      <= 1'b0;
            r_addr      <= '0;
            r_buf_start <= 8'h00;
            r_buf_count <= 9'h000;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_command   <= n_command;
            r_byte_idx  <= n_byte_idx;
            r_wen       <= n_wen;
            r_four      <= n_four;
            r_addr      <= n_addr;
            r_buf_start <= n_buf_start;
            r_buf_count <= n_buf_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    snfce_array #(
        .ADDR_BITS(ADDR_BITS)
    ) u_array (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (arr_req),
        .i_addr    (r_addr[ADDR_BITS-1:0]),
        .o_busy    (arr_busy),
        .o_rd_data (arr_rd_data)
    );

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_out_data;

endmodule

@@ sim/spi_nor_flash_command_engine_test.sv @@
`timescale 1ns / 1ps

module spi_nor_flash_command_engine_test;
    import snfce_pkg::*;

    localparam int ADDR_BITS      = 16;
    localparam int FLASH_BYTES    = 1 << ADDR_BITS;
    localparam int SECTOR_BYTES   = 1 << SECTOR_BITS;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam logic [159:0] ID_CODE =
        160'h20BA1910_00002321_61340700_30001717_06124B01;

    typedef struct packed {
        t_func      f;
        logic [7:0] b;
        logic       typed;
        logic [7:0] want;
    } t_row;

    localparam int DIR_ROWS = 27;
    localparam t_row DIR_TAB [DIR_ROWS] = '{
        '{FN_READ,    8'h00,      1'b1, 8'h00},
        '{FN_SELECT,  8'h00,      1'b1, 8'h00},
        '{FN_WRITE,   OP_WREN,    1'b0, 8'h00},
        '{FN_SELECT,  8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   OP_STATUS,  1'b0, 8'h00},
        '{FN_READ,    8'h00,      1'b1, 8'h02},
        '{FN_SELECT,  8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   OP_PROGRAM, 1'b0, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_WRITE,   8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   8'hA5,      1'b0, 8'h00},
        '{FN_RELEASE, 8'h00,      1'b1, 8'h00},
        '{FN_SELECT,  8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   OP_ADDR4,   1'b0, 8'h00},
        '{FN_SELECT,  8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   OP_READ,    1'b0, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_READ,    8'h00,      1'b1, 8'h00},
        '{FN_WRITE,   8'hFF,      1'b0, 8'h00},
        '{FN_WRITE,   8'h00,      1'b0, 8'h00},
        '{FN_READ,    8'h00,      1'b0, 8'h00},
        '{FN_SELECT,  8'h00,      1'b0, 8'h00},
        '{FN_WRITE,   OP_ERASE,   1'b0, 8'h00},
        '{FN_RELEASE, 8'h00,      1'b1, 8'h00}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_stall;
    t_func      i_func       = FN_SELECT;
    logic [7:0] i_write_byte = 8'h00;
    logic       o_valid;
    logic       i_stall      = 1'b0;
    logic [7:0] o_read_byte;

    logic [7:0]  cur_cmd;
    logic [2:0]  wr_count;
    logic        wel;
    logic        addr4;
    logic [31:0] cur_addr;
    logic [7:0]  pbuf [0:255];
    logic [7:0]  pbuf_head;
    logic [8:0]  pbuf_count;
    logic [7:0]  flash_mem [0:FLASH_BYTES-1];

    logic [7:0] pending_read_bytes [$];
    int errors        = 0;
    int items_sent    = 0;
    int idle_cycles   = 0;
    int read_events   = 0;
    int prog_commits  = 0;
    int erase_commits = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 88;
    bit hold_req      = 1'b0;

    spi_nor_flash_command_engine #(
        .ADDR_BITS(ADDR_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func(i_func),
        .i_write_byte(i_write_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_read_byte(o_read_byte)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] flash_predict(input t_func f, input logic [7:0] b);
        logic [7:0]           r;
        logic [2:0]           alen;
        logic [31:0]          a;
        logic [ADDR_BITS-1:0] base;
        int                   n;
        r = 8'h00;
        alen = addr4 ? ADDR_LEN4 : ADDR_LEN3;
        case (f)
            FN_SELECT: begin
                cur_cmd = OP_NONE;
                wr_count = 3'd0;
                cur_addr = 32'd0;
            end
            FN_RELEASE: begin
                if (cur_cmd == OP_PROGRAM) begin
                    a = cur_addr;
                    for (n = 0; n < pbuf_count; n++) begin
                        flash_mem[a[ADDR_BITS-1:0]] = pbuf[pbuf_head + 8'(n)];
                        a[7:0] = a[7:0] + 8'd1;
                    end
                    wel = 1'b0;
                    prog_commits++;
                end else if (cur_cmd == OP_ERASE) begin
                    base = cur_addr[ADDR_BITS-1:0];
                    base[SECTOR_BITS-1:0] = '0;
                    for (n = 0; n < SECTOR_BYTES; n++) begin
                        flash_mem[base + ADDR_BITS'(n)] = ERASED_BYTE;
                    end
                    wel = 1'b0;
                    erase_commits++;
                end
            end
            FN_WRITE: begin
                if (wr_count == 3'd0) begin
                    cur_cmd = b;
                    case (b)
                        OP_PROGRAM: begin
                            if (!wel) begin
                                cur_cmd = OP_NONE;
                            end
                            pbuf_head = 8'd0;
                            pbuf_count = 9'd0;
                        end
                        OP_WRDI:  wel = 1'b0;
                        OP_WREN:  wel = 1'b1;
                        OP_ERASE: begin
                            if (!wel) begin
                                cur_cmd = OP_NONE;
                            end
                        end
                        OP_ADDR4: addr4 = 1'b1;
                        OP_ADDR3: addr4 = 1'b0;
                        default: ;
                    endcase
                end else if (cur_cmd == OP_PROGRAM || cur_cmd == OP_READ ||
                             cur_cmd == OP_ERASE) begin
                    if (wr_count <= alen) begin
                        cur_addr = {cur_addr[23:0], b};
                    end else if (cur_cmd == OP_PROGRAM) begin
                        pbuf[pbuf_head + pbuf_count[7:0]] = b;
                        if (pbuf_count == PAGE_FULL) begin
                            pbuf_head = pbuf_head + 8'd1;
                        end else begin
                            pbuf_count = pbuf_count + 9'd1;
                        end
                    end
                end
                if (wr_count < IDX_MAX) begin
                    wr_count = wr_count + 3'd1;
                end
            end
            default: begin
                read_events++;
                if (wr_count != 3'd0) begin
                    case (cur_cmd)
                        OP_READ: begin
                            if (wr_count > alen) begin
                                r = flash_mem[cur_addr[ADDR_BITS-1:0]];
                                cur_addr = cur_addr + 32'd1;
                            end
                        end
                        OP_STATUS: r = {6'd0, wel, 1'b0};
                        OP_ID: begin
                            if (cur_addr < ID_LEN) begin
                                n = cur_addr;
                                r = ID_CODE[8'(159 - 8 * n) -: 8];
                                cur_addr = cur_addr + 32'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    task automatic push_event(input t_func f, input logic [7:0] b,
                              input logic typed = 1'b0, input logic [7:0] want = 8'h00);
        logic [7:0] got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_write_byte <= b;
        do @(posedge i_clk); while (o_stall);
        got = flash_predict(f, b);
        pending_read_bytes.push_back(typed ? want : got);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_sequence();
        int          pick;
        int          n_addr;
        int          n_data;
        int          k;
        logic [7:0]  op;
        logic [31:0] addr;
        logic        is_write;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            push_event(t_func'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) op = OP_READ;
        else if (pick < 45) op = OP_PROGRAM;
        else if (pick < 50) op = OP_ERASE;
        else if (pick < 58) op = OP_STATUS;
        else if (pick < 65) op = OP_ID;
        else if (pick < 73) op = OP_WREN;
        else if (pick < 78) op = OP_WRDI;
        else if (pick < 84) op = OP_ADDR4;
        else if (pick < 90) op = OP_ADDR3;
        else op = 8'($urandom);
        if ((op == OP_PROGRAM || op == OP_ERASE) && $urandom_range(0, 4) != 0) begin
            push_event(FN_SELECT, 8'($urandom));
            push_event(FN_WRITE, OP_WREN);
            push_event(FN_RELEASE, 8'($urandom));
        end
        push_event(FN_SELECT, 8'($urandom));
        push_event(FN_WRITE, op);
        if (op == OP_READ || op == OP_PROGRAM || op == OP_ERASE) begin
            addr = $urandom;
            if ($urandom_range(0, 3) != 0) begin
                addr[15:12] = 4'($urandom_range(14, 15));
                addr[11:8] = 4'($urandom_range(0, 3));
            end
            n_addr = addr4 ? 4 : 3;
            for (k = n_addr - 1; k >= 0; k--) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_event(FN_READ, 8'($urandom));
                end
                push_event(FN_WRITE, addr[8 * k +: 8]);
            end
        end
        case (op)
            OP_READ:    n_data = $urandom_range(1, 12);
            OP_PROGRAM: n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 262)
                                                              : $urandom_range(1, 16);
            OP_STATUS:  n_data = $urandom_range(1, 4);
            OP_ID:      n_data = $urandom_range(1, 24);
            default:    n_data = $urandom_range(0, 3);
        endcase
        for (k = 0; k < n_data; k++) begin
            is_write = (op == OP_PROGRAM) != ($urandom_range(0, 9) == 0);
            push_event(is_write ? FN_WRITE : FN_READ, 8'($urandom));
        end
        if ($urandom_range(0, 15) != 0) begin
            push_event(FN_RELEASE, 8'($urandom));
        end
        if ($urandom_range(0, 15) == 0) begin
            push_event(FN_RELEASE, 8'($urandom));
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_read_byte
        logic [7:0] want_byte;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_read_bytes.size() == 0) begin
                $display("%0t: read byte mismatch, expected none, got %02h",
                         $time, o_read_byte);
                errors++;
            end else begin
                want_byte = pending_read_bytes.pop_front();
                if (o_read_byte !== want_byte) begin
                    $display("%0t: read byte mismatch, expected %02h, got %02h",
                             $time, want_byte, o_read_byte);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        int ph;
        for (n = 0; n < FLASH_BYTES; n++) begin
            flash_mem[ADDR_BITS'(n)] = ERASED_BYTE;
        end
        cur_cmd = OP_NONE;
        wr_count = 3'd0;
        wel = 1'b0;
        addr4 = 1'b0;
        cur_addr = 32'd0;
        pbuf_head = 8'd0;
        pbuf_count = 9'd0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (n = 0; n < DIR_ROWS; n++) begin
            push_event(DIR_TAB[n].f, DIR_TAB[n].b, DIR_TAB[n].typed, DIR_TAB[n].want);
        end
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 36 : 0;
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            while (items_sent < DIR_ROWS + (ph + 1) * PHASE_ITEMS) begin
                run_sequence();
            end
        end
        i_valid <= 1'b0;
        while (pending_read_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Drove %0d bus transactions (%0d reads), committing %0d page programs",
                 items_sent, read_events, prog_commits);
        $display("and %0d subsector erases, under three idle profiles and one long hold.",
                 erase_commits);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/snfce_pkg.sv
rtl/snfce_array.sv
rtl/spi_nor_flash_command_engine.sv
sim/spi_nor_flash_command_engine_test.sv
